>>> src/sde_pkg.sv
package sde_pkg;

    localparam int DeckDepth = 128;
    localparam int IdxW = $clog2(DeckDepth);
    localparam int CntW = $clog2(DeckDepth + 1);
    localparam int RandW = 15;
    localparam int RandomMax = 32767;
    localparam int ItemW = 23;
    localparam int QDepth = 4;
    localparam int QPtrW = $clog2(QDepth);

    typedef enum logic [2:0] {
        K_LOAD    = 3'd0,
        K_SHUFFLE = 3'd1,
        K_RANDOM  = 3'd2,
        K_DRAW    = 3'd3,
        K_RETURN  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_REJECTED = 3'd3,
        ST_NO_SHUF  = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       symbol;
        logic [7:0]       points;
        logic [6:0]       item_id;
        logic [RandW-1:0] random_word;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] out_symbol;
        logic [7:0] out_points;
        logic [6:0] out_id;
        logic [7:0] remaining;
        logic       shuffle_active;
    } t_out_word;

    typedef struct packed {
        logic [7:0] sym;
        logic [7:0] pts;
        logic [6:0] id;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_RD_A,
        S_RD_B,
        S_WR_A,
        S_WR_B,
        S_DRAW_RD,
        S_DRAW_WAIT,
        S_OUT
    } t_state;

endpackage

>>> src/sde_ram.sv
module sde_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> src/sde_front.sv
module sde_front import sde_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_word i_word,
    output logic     o_empty,
    input  logic     i_pop,
    output t_in_word o_word
);
    // small queue parting intake from the deck engine
    t_in_word          r_q [QDepth];
    logic [QPtrW-1:0]  r_wp, r_rp;
    logic [QPtrW:0]    r_cnt;
    logic              wr, rd;

    assign o_full  = (r_cnt == (QPtrW+1)'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign wr = i_push && !o_full;
    assign rd = i_pop && !o_empty;
    assign o_word = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) r_q[r_wp] <= i_word;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
        end
    end
endmodule

>>> src/sde_back.sv
module sde_back import sde_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_pop,
    input  t_in_word  i_cmd,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_word o_result
);
    t_state r_state, n_state;
    t_in_word r_cmd;
    logic [CntW-1:0] r_loaded, r_remain;
    logic [IdxW-1:0] r_pos, r_pick;
    logic r_shuf;
    t_out_word r_res;
    logic r_res_valid;
    // remainder unit
    logic [RandW:0] r_rem_w, r_rem_l;
    logic [RandW-1:0] r_quo_w, r_quo_l;
    logic [3:0] r_bit;
    t_item r_a, r_b;

    logic ram_we;
    logic [IdxW-1:0] ram_wa, ram_ra;
    t_item ram_wd, ram_rd;

    sde_ram #(.Width(ItemW), .Depth(DeckDepth)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(ram_wd),
        .i_raddr(ram_ra), .o_rdata(ram_rd)
    );

    logic [IdxW:0] range_w;
    assign range_w = {1'b0, r_pos} + 1'b1;
    logic [RandW:0] rs_w, rs_l;
    assign rs_w = {r_rem_w[RandW-1:0], r_quo_w[RandW-1]};
    assign rs_l = {r_rem_l[RandW-1:0], r_quo_l[RandW-1]};

    logic take;
    assign take = i_cmd_valid && (r_state == S_IDLE) && !r_res_valid;
    assign o_cmd_pop = take;
    assign o_empty = !r_res_valid;
    assign o_result = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (take) begin
                case (i_cmd.kind)
                    K_RANDOM: n_state = (r_shuf && r_pos != '0) ? S_DIV : S_OUT;
                    K_DRAW:   n_state = (r_remain != '0) ? S_DRAW_RD : S_OUT;
                    default:  n_state = S_OUT;
                endcase
            end
            S_DIV:       if (r_bit == 4'd0) n_state = S_RD_A;
            S_RD_A:      n_state = S_RD_B;
            S_RD_B:      n_state = S_WR_A;
            S_WR_A:      n_state = S_WR_B;
            S_WR_B:      n_state = S_OUT;
            S_DRAW_RD:   n_state = S_DRAW_WAIT;
            S_DRAW_WAIT: n_state = S_OUT;
            S_OUT:       n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    logic limit_rej;
    // (RANDOM_MAX+1) mod range is r_rem_l; reject word above RANDOM_MAX - that
    assign limit_rej = {1'b0, r_cmd.random_word} > (RandW+1)'(RandomMax) - r_rem_l;

    // result fields known as soon as the word is taken
    t_out_word take_res;
    always_comb begin
        take_res = '0;
        take_res.status = ST_OK;
        case (i_cmd.kind)
            K_LOAD: if (r_remain >= CntW'(DeckDepth) || r_loaded >= CntW'(DeckDepth))
                take_res.status = ST_FULL;
            K_RANDOM: if (!(r_shuf && r_pos != '0)) take_res.status = ST_NO_SHUF;
            K_DRAW: if (r_remain == '0) take_res.status = ST_EMPTY;
            K_RETURN: if (r_remain >= CntW'(DeckDepth)) take_res.status = ST_FULL;
            default: ;
        endcase
    end

    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_pos;
        ram_wd = r_b;
        ram_ra = r_pick;
        case (r_state)
            S_IDLE: begin
                if (take && (i_cmd.kind == K_LOAD || i_cmd.kind == K_RETURN)) begin
                    ram_we = (r_remain < CntW'(DeckDepth)) &&
                             (i_cmd.kind == K_RETURN || r_loaded < CntW'(DeckDepth));
                    ram_wa = r_remain[IdxW-1:0];
                    ram_wd = {i_cmd.symbol, i_cmd.points,
                              (i_cmd.kind == K_LOAD) ? r_loaded[6:0] : i_cmd.item_id};
                end
            end
            S_RD_A:    ram_ra = r_pos;
            S_WR_A: begin
                ram_we = !limit_rej;
                ram_wa = r_pick;
                ram_wd = r_b;
            end
            S_WR_B: begin
                ram_we = !limit_rej;
                ram_wa = r_pos;
                ram_wd = r_a;
            end
            S_DRAW_RD: ram_ra = r_remain[IdxW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_loaded <= '0;
            r_remain <= '0;
            r_pos <= '0;
            r_shuf <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_res_valid && i_pop) r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (take) begin
                    r_cmd <= i_cmd;
                    r_res <= take_res;
                    case (i_cmd.kind)
                        K_LOAD: begin
                            r_shuf <= 1'b0;
                            if (r_remain < CntW'(DeckDepth) && r_loaded < CntW'(DeckDepth)) begin
                                r_remain <= r_remain + 1'b1;
                                r_loaded <= r_loaded + 1'b1;
                            end
                        end
                        K_SHUFFLE: begin
                            if (r_remain > CntW'(1)) begin
                                r_pos <= IdxW'(r_remain - 1'b1);
                                r_shuf <= 1'b1;
                            end else begin
                                r_pos <= '0;
                                r_shuf <= 1'b0;
                            end
                        end
                        K_RANDOM: begin
                            if (!(r_shuf && r_pos != '0)) r_shuf <= 1'b0;
                            r_rem_w <= '0;
                            r_rem_l <= '0;
                            r_quo_w <= i_cmd.random_word;
                            // RANDOM_MAX+1 = 2^15, whose top bit is shifted in first
                            r_quo_l <= '0;
                            r_bit <= 4'd15;
                        end
                        K_DRAW: begin
                            r_shuf <= 1'b0;
                            if (r_remain != '0) r_remain <= r_remain - 1'b1;
                        end
                        K_RETURN: begin
                            r_shuf <= 1'b0;
                            if (r_remain < CntW'(DeckDepth)) r_remain <= r_remain + 1'b1;
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    // one restoring step per cycle for word and for 2^15
                    // the first step only covers bit 15, which the word lacks
                    if (r_bit == 4'd15) begin
                        r_rem_l <= 1'b1 >= (RandW+1)'(range_w) ? '0 : (RandW+1)'(1);
                    end else begin
                        if (rs_w >= (RandW+1)'(range_w))
                            r_rem_w <= rs_w - (RandW+1)'(range_w);
                        else r_rem_w <= rs_w;
                        r_quo_w <= {r_quo_w[RandW-2:0], 1'b0};
                        if (rs_l >= (RandW+1)'(range_w))
                            r_rem_l <= rs_l - (RandW+1)'(range_w);
                        else r_rem_l <= rs_l;
                        r_quo_l <= {r_quo_l[RandW-2:0], 1'b0};
                    end
                    r_bit <= r_bit - 1'b1;
                end
                S_RD_A: r_pick <= IdxW'(r_rem_w);
                S_RD_B: r_b <= ram_rd;
                S_WR_A: r_a <= ram_rd;
                S_WR_B: begin
                    if (limit_rej) r_res.status <= ST_REJECTED;
                    else begin
                        r_pos <= r_pos - 1'b1;
                        if (r_pos == IdxW'(1)) r_shuf <= 1'b0;
                    end
                end
                S_DRAW_WAIT: begin
                    r_res.out_symbol <= ram_rd.sym;
                    r_res.out_points <= ram_rd.pts;
                    r_res.out_id <= ram_rd.id;
                end
                S_OUT: begin
                    r_res.remaining <= 8'(r_remain);
                    r_res.shuffle_active <= r_shuf;
                    r_res_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule

>>> src/shuffled_deck_engine_unit.sv
// load, return, begin-shuffle, unused kinds and a random word with no pass go straight to
// the result; a draw with cards left reads the deck memory first; a random word in a pass:
// a 16-step restoring remainder, one bit a cycle, then a read-read-write-write swap on the
// one-read one-write deck memory; one word at a time in the engine, the next taken the
// cycle after a pop; synchronous active-low reset clears counts, queue and result flag
module shuffled_deck_engine_unit import sde_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_word  i_word,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_word
);
    logic q_empty, q_pop;
    t_in_word q_word;

    sde_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_word(i_word), .o_empty(q_empty), .i_pop(q_pop), .o_word(q_word)
    );

    sde_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(!q_empty), .o_cmd_pop(q_pop),
        .i_cmd(q_word), .o_empty(empty), .i_pop(pop), .o_result(o_word)
    );
endmodule

>>> src/sde_checker.sv
module sde_checker import sde_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_word o_word
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_word)) else $error("result changed while stalled");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_word.remaining <= 8'(DeckDepth)) else $error("remaining too big");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_word.status != ST_OK |-> o_word.out_id == '0 && o_word.out_symbol == '0)
        else $error("item fields set on failure");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("reset state wrong");
endmodule

bind shuffled_deck_engine_unit sde_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full), .empty(empty), .pop(pop),
    .o_word(o_word)
);

>>> tb/tb_shuffled_deck_engine_unit.sv
module tb_shuffled_deck_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import sde_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_word  i_word;
    logic      empty;
    logic      pop;
    t_out_word o_word;

    shuffled_deck_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_word  (i_word),
        .empty   (empty),
        .pop     (pop),
        .o_word  (o_word)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // predictor state
    t_item       deck_mem [DeckDepth];
    int unsigned loaded_n = 0;
    int unsigned left_n = 0;
    int unsigned shuf_pos = 0;
    bit          shuf_on = 0;

    t_in_word  pending_words [$];
    t_out_word expected_words [$];
    int        errors = 0;
    int        cycles = 0;
    int        send_idle_pct;
    int        recv_idle_pct;

    function automatic t_out_word predict_step(t_in_word w);
        t_out_word r;
        t_item     t;
        int unsigned range_n;
        int unsigned lim;
        int unsigned pick;
        r = '0;
        r.status = ST_OK;
        case (w.kind)
            K_LOAD: begin
                shuf_on = 0;
                if (left_n >= DeckDepth || loaded_n >= DeckDepth) begin
                    r.status = ST_FULL;
                end else begin
                    deck_mem[left_n] = '{w.symbol, w.points, loaded_n[6:0]};
                    left_n++;
                    loaded_n++;
                end
            end
            K_SHUFFLE: begin
                if (left_n > 1) begin
                    shuf_pos = left_n - 1;
                    shuf_on = 1;
                end else begin
                    shuf_pos = 0;
                    shuf_on = 0;
                end
            end
            K_RANDOM: begin
                if (!shuf_on || shuf_pos == 0 || shuf_pos >= DeckDepth) begin
                    shuf_on = 0;
                    r.status = ST_NO_SHUF;
                end else begin
                    range_n = shuf_pos + 1;
                    lim = RandomMax - ((RandomMax + 1) % range_n);
                    if (w.random_word > lim) begin
                        r.status = ST_REJECTED;
                    end else begin
                        pick = w.random_word % range_n;
                        t = deck_mem[pick];
                        deck_mem[pick] = deck_mem[shuf_pos];
                        deck_mem[shuf_pos] = t;
                        shuf_pos--;
                        if (shuf_pos == 0) shuf_on = 0;
                    end
                end
            end
            K_DRAW: begin
                shuf_on = 0;
                if (left_n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    left_n--;
                    r.out_symbol = deck_mem[left_n].sym;
                    r.out_points = deck_mem[left_n].pts;
                    r.out_id     = deck_mem[left_n].id;
                end
            end
            K_RETURN: begin
                shuf_on = 0;
                if (left_n >= DeckDepth) begin
                    r.status = ST_FULL;
                end else begin
                    deck_mem[left_n] = '{w.symbol, w.points, w.item_id};
                    left_n++;
                end
            end
            default: ;
        endcase
        r.remaining = left_n[7:0];
        r.shuffle_active = shuf_on;
        return r;
    endfunction

    function automatic t_in_word make_word(logic [2:0] k);
        t_in_word w;
        w.kind        = k;
        w.symbol      = 8'($urandom_range(255, 0));
        w.points      = 8'($urandom_range(255, 0));
        w.item_id     = 7'($urandom_range(127, 0));
        w.random_word = 15'($urandom_range(32767, 0));
        return w;
    endfunction

    task automatic append_word(t_in_word w);
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic queue_word(logic [2:0] k, logic [14:0] rw = 15'h0, bit keep_rw = 0);
        t_in_word w;
        w = make_word(k);
        if (keep_rw) w.random_word = rw;
        append_word(w);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push   <= 1'b0;
            i_word <= '0;
        end else begin
            if (push && !full) begin
                expected_words.insert(expected_words.size(), predict_step(i_word));
                void'(pending_words.pop_front());
            end
            if (pending_words.size() > 0 && ($urandom_range(99, 0) >= send_idle_pct)) begin
                push   <= 1'b1;
                i_word <= pending_words[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_words.size() == 0) begin
                    $display("%0t unexpected word %h", $time, o_word);
                    errors++;
                end else begin
                    if (o_word !== expected_words[0]) begin
                        $display("%0t mismatch expected %h actual %h",
                                 $time, expected_words[0], o_word);
                        errors++;
                    end
                    void'(expected_words.pop_front());
                end
            end
            pop <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || push || expected_words.size() > 0)
            @(posedge i_clk);
    endtask

    // a round: fill, shuffle with n+2 random words, sometimes a word of any kind, then draw out
    task automatic add_round();
        int n;
        n = $urandom_range(3) == 0 ? $urandom_range(40, 2) : $urandom_range(8, 2);
        if (loaded_n + n > DeckDepth) n = 1;
        for (int i = 0; i < n; i++) queue_word($urandom_range(3) == 0 ? K_RETURN : K_LOAD);
        queue_word(K_SHUFFLE);
        for (int i = 0; i < n + 2; i++) queue_word(K_RANDOM);
        if ($urandom_range(4) == 0) queue_word(3'($urandom_range(7, 0)));
        for (int i = 0; i < n + $urandom_range(1, 0); i++) queue_word(K_DRAW);
    endtask

    initial begin
        int n_items;
        i_rst_n = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 86;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty draw, stray word, short shuffle, edge random words, unused kinds, returns
        queue_word(K_DRAW);
        queue_word(K_RANDOM);
        queue_word(K_LOAD);
        queue_word(K_SHUFFLE);
        queue_word(K_LOAD);
        queue_word(K_SHUFFLE);
        queue_word(K_SHUFFLE);
        queue_word(K_RANDOM, 15'h7fff, 1);
        queue_word(K_RANDOM, 15'h7ffe, 1);
        queue_word(K_RANDOM, 15'h0, 1);
        queue_word(K_RANDOM, 15'h0, 1);
        queue_word(3'd5);
        queue_word(3'd6);
        queue_word(3'd7);
        append_word(t_in_word'{K_RETURN, 8'hff, 8'hff, 7'h7f, 15'h7fff});
        append_word(t_in_word'{K_RETURN, 8'h00, 8'h00, 7'h00, 15'h0});
        queue_word(K_SHUFFLE);
        queue_word(K_LOAD);
        for (int i = 0; i < 6; i++) queue_word(K_DRAW);
        wait_drained();

        n_items = 0;
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle_pct = 86; recv_idle_pct = 7; end
            if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
            while (n_items < (ph + 1) * 250) begin
                if ($urandom_range(4) == 0) begin
                    queue_word(3'($urandom_range(7, 0)));
                end else begin
                    add_round();
                end
                n_items = n_items + pending_words.size();
                wait_drained();
            end
        end

        // fill to capacity for full cases, shuffle part way, then empty the deck
        send_idle_pct = 0;
        while (loaded_n + pending_words.size() < DeckDepth + 2) queue_word(K_LOAD);
        queue_word(K_RETURN);
        queue_word(K_SHUFFLE);
        for (int i = 0; i < 20; i++) queue_word(K_RANDOM);
        for (int i = 0; i < DeckDepth + 1; i++) queue_word(K_DRAW);
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
